>>> rtl/occupancy_grid_frontier_test_defines.svh
// ----------------------------------------------------------------------------
// Frontier test assertion macros
// Clocked on clk and disabled in rst; same-cycle and next-cycle implications.
// ----------------------------------------------------------------------------
`ifndef OCCUPANCY_GRID_FRONTIER_TEST_DEFINES_SVH
`define OCCUPANCY_GRID_FRONTIER_TEST_DEFINES_SVH

// antecedent implies consequent in the same cycle
`define OGFT_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// antecedent implies consequent in the next cycle
`define OGFT_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/ogft_pkg.sv
// ----------------------------------------------------------------------------
// ogft_pkg
// Grid sizes, field widths, codes and controller/datapath bundles.
// ----------------------------------------------------------------------------
package ogft_pkg;

  localparam int MAX_ROWS = 256;
  localparam int MAX_COLS = 256;

  localparam int ROW_AW = $clog2(MAX_ROWS);
  localparam int COL_AW = $clog2(MAX_COLS);
  localparam int MEM_AW = ROW_AW + COL_AW;

  localparam int ROW_PW = (ROW_AW + 1 > 10) ? ROW_AW + 1 : 10;
  localparam int COL_PW = (COL_AW + 1 > 10) ? COL_AW + 1 : 10;

  localparam int ROW_FW = 8;
  localparam int COL_FW = 8;
  localparam int VAL_W  = 8;
  localparam int LIM_W  = 9;
  localparam int CNT_W  = 4;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 9;

  localparam int WIN      = 5;
  localparam int WIN_HALF = 2;
  localparam int WIN_IW   = 3;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ROWS    = 3'd0,
    CFG_COLS    = 3'd1,
    CFG_FREE    = 3'd2,
    CFG_UNKNOWN = 3'd3,
    CFG_MIN_CNT = 3'd4
  } cfg_idx_t;

  typedef enum logic {
    REQ_WRITE = 1'b0,
    REQ_QUERY = 1'b1
  } req_kind_t;

  typedef struct packed {
    logic in_ready;
    logic scan_step;
    logic out_load;
  } ctrl_cmd_t;

  typedef struct packed {
    logic in_valid;
    logic in_query;
    logic scan_last;
    logic out_full;
  } dp_stat_t;

endpackage

>>> rtl/ogft_req_if.sv
// ----------------------------------------------------------------------------
// ogft_req_if
// Request channel: cell write or frontier query.
// ----------------------------------------------------------------------------
interface ogft_req_if import ogft_pkg::*; ();
  logic              valid;
  logic              ready;
  logic              req_type;
  logic [ROW_FW-1:0] cell_row;
  logic [COL_FW-1:0] cell_col;
  logic [VAL_W-1:0]  cell_value;

  modport source (output valid, req_type, cell_row, cell_col, cell_value, input ready);
  modport sink (input valid, req_type, cell_row, cell_col, cell_value, output ready);
endinterface

>>> rtl/ogft_rsp_if.sv
// ----------------------------------------------------------------------------
// ogft_rsp_if
// Result channel: queried cell and its frontier flag.
// ----------------------------------------------------------------------------
interface ogft_rsp_if import ogft_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [ROW_FW-1:0] result_row;
  logic [COL_FW-1:0] result_col;
  logic              is_frontier;

  modport source (output valid, result_row, result_col, is_frontier, input ready);
  modport sink (input valid, result_row, result_col, is_frontier, output ready);
endinterface

>>> rtl/ogft_cfg_if.sv
// ----------------------------------------------------------------------------
// ogft_cfg_if
// Configuration write channel: register index and data word.
// ----------------------------------------------------------------------------
interface ogft_cfg_if import ogft_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

>>> rtl/ogft_ram.sv
// ----------------------------------------------------------------------------
// ogft_ram
// Single-port RAM with registered read data.
// ----------------------------------------------------------------------------
module ogft_ram #(
  parameter int AW = 16,
  parameter int DW = 8
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] addr,
  input  logic [DW-1:0] wdata,
  output logic [DW-1:0] rdata
);

  logic [DW-1:0] mem [2**AW];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

>>> rtl/ogft_ctrl.sv
// ----------------------------------------------------------------------------
// ogft_ctrl
// Sequencer: accept, 5x5 window scan, drain, evaluate and hand off result.
// ----------------------------------------------------------------------------
`include "occupancy_grid_frontier_test_defines.svh"

module ogft_ctrl import ogft_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  dp_stat_t  stat,
  output ctrl_cmd_t cmd
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN,
    ST_EVAL
  } state_t;

  state_t state;
  state_t state_next;

  always_comb begin
    state_next    = state;
    cmd.in_ready  = 1'b0;
    cmd.scan_step = 1'b0;
    cmd.out_load  = 1'b0;
    unique case (state)
      ST_IDLE: begin
        cmd.in_ready = 1'b1;
        if (stat.in_valid && stat.in_query) begin
          state_next = ST_SCAN;
        end
      end
      ST_SCAN: begin
        cmd.scan_step = 1'b1;
        if (stat.scan_last) begin
          state_next = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        state_next = ST_EVAL;
      end
      ST_EVAL: begin
        if (!stat.out_full) begin
          cmd.out_load = 1'b1;
          state_next   = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  `OGFT_ASSERT_NOW(a_eval_after_drain, state == ST_EVAL,
    $past(state) == ST_DRAIN || $past(state) == ST_EVAL, "eval entered without drain")
  `OGFT_ASSERT_NEXT(a_scan_ends, cmd.scan_step && stat.scan_last,
    !cmd.scan_step, "scan ran past last tap")
  `OGFT_ASSERT_NOW(a_load_when_free, cmd.out_load, !stat.out_full,
    "result loaded over pending word")

endmodule

>>> rtl/ogft_dp.sv
// ----------------------------------------------------------------------------
// ogft_dp
// Datapath: config registers, cell store, window capture, frontier evaluation.
// ----------------------------------------------------------------------------
`include "occupancy_grid_frontier_test_defines.svh"

module ogft_dp import ogft_pkg::*; (
  input  logic          clk,
  input  logic          rst,
  ogft_req_if.sink      req,
  ogft_rsp_if.source    rsp,
  ogft_cfg_if.sink      cfg,
  input  ctrl_cmd_t     cmd,
  output dp_stat_t      stat
);

  logic [LIM_W-1:0] rows_in_use;
  logic [LIM_W-1:0] cols_in_use;
  logic [VAL_W-1:0] free_code;
  logic [VAL_W-1:0] unknown_code;
  logic [CNT_W-1:0] min_unknown_count;

  logic              accept;
  logic [ROW_FW-1:0] q_row;
  logic [COL_FW-1:0] q_col;
  logic [WIN_IW-1:0] sr;
  logic [WIN_IW-1:0] sc;
  logic              scan_last;

  logic [ROW_PW-1:0] eff_rows;
  logic [COL_PW-1:0] eff_cols;
  logic [ROW_PW-1:0] row_sum;
  logic [COL_PW-1:0] col_sum;
  logic [ROW_PW-1:0] nr;
  logic [COL_PW-1:0] nc;
  logic              tap_in;

  logic              mem_we;
  logic [MEM_AW-1:0] mem_addr;
  logic [VAL_W-1:0]  mem_rdata;

  logic              tap_vld;
  logic              tap_ok;
  logic [WIN_IW-1:0] tap_r;
  logic [WIN_IW-1:0] tap_c;

  logic [WIN-1:0][WIN-1:0] unk;
  logic                    ctr_free;
  logic                    frontier;

  logic              out_valid;
  logic [ROW_FW-1:0] out_row;
  logic [COL_FW-1:0] out_col;
  logic              out_front;

  function automatic logic frontier_eval(input logic [WIN-1:0][WIN-1:0] m,
                                         input logic [CNT_W-1:0] thr);
    logic             hit;
    logic [CNT_W-1:0] cnt;
    hit = 1'b0;
    for (int a = 0; a < 3; a++) begin
      for (int b = 0; b < 3; b++) begin
        if (!(a == 1 && b == 1)) begin
          cnt = '0;
          for (int i = 0; i < 3; i++) begin
            for (int j = 0; j < 3; j++) begin
              if (!(i == 1 && j == 1)) begin
                cnt = cnt + CNT_W'(m[a + i][b + j]);
              end
            end
          end
          if (m[a + 1][b + 1] && cnt >= thr) begin
            hit = 1'b1;
          end
        end
      end
    end
    return hit;
  endfunction

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      rows_in_use       <= LIM_W'(256);
      cols_in_use       <= LIM_W'(256);
      free_code         <= '0;
      unknown_code      <= '1;
      min_unknown_count <= CNT_W'(4);
    end else if (cfg.valid) begin
      unique case (cfg.index)
        CFG_ROWS:    rows_in_use       <= cfg.data[LIM_W-1:0];
        CFG_COLS:    cols_in_use       <= cfg.data[LIM_W-1:0];
        CFG_FREE:    free_code         <= cfg.data[VAL_W-1:0];
        CFG_UNKNOWN: unknown_code      <= cfg.data[VAL_W-1:0];
        CFG_MIN_CNT: min_unknown_count <= cfg.data[CNT_W-1:0];
        default: ;
      endcase
    end
  end

  assign req.ready = cmd.in_ready;
  assign accept    = req.valid && req.ready;

  assign stat.in_valid  = req.valid;
  assign stat.in_query  = (req.req_type == REQ_QUERY);
  assign stat.scan_last = scan_last;
  assign stat.out_full  = out_valid && !rsp.ready;

  assign scan_last = (sr == WIN_IW'(WIN - 1)) && (sc == WIN_IW'(WIN - 1));

  always_ff @(posedge clk) begin
    if (accept) begin
      q_row <= req.cell_row;
      q_col <= req.cell_col;
      sr    <= '0;
      sc    <= '0;
    end else if (cmd.scan_step) begin
      if (sc == WIN_IW'(WIN - 1)) begin
        sc <= '0;
        sr <= sr + 1'b1;
      end else begin
        sc <= sc + 1'b1;
      end
    end
  end

  assign eff_rows = (ROW_PW'(rows_in_use) > ROW_PW'(MAX_ROWS)) ? ROW_PW'(MAX_ROWS)
                                                               : ROW_PW'(rows_in_use);
  assign eff_cols = (COL_PW'(cols_in_use) > COL_PW'(MAX_COLS)) ? COL_PW'(MAX_COLS)
                                                               : COL_PW'(cols_in_use);
  assign row_sum  = ROW_PW'(q_row) + ROW_PW'(sr);
  assign col_sum  = COL_PW'(q_col) + COL_PW'(sc);
  assign nr       = row_sum - ROW_PW'(WIN_HALF);
  assign nc       = col_sum - COL_PW'(WIN_HALF);
  assign tap_in   = (row_sum >= ROW_PW'(WIN_HALF)) && (nr < eff_rows) &&
                    (col_sum >= COL_PW'(WIN_HALF)) && (nc < eff_cols);

  assign mem_we = accept && (req.req_type == REQ_WRITE) &&
                  (ROW_PW'(req.cell_row) < ROW_PW'(MAX_ROWS)) &&
                  (COL_PW'(req.cell_col) < COL_PW'(MAX_COLS));

  always_comb begin
    if (mem_we) begin
      mem_addr = {ROW_AW'(req.cell_row), COL_AW'(req.cell_col)};
    end else begin
      mem_addr = {nr[ROW_AW-1:0], nc[COL_AW-1:0]};
    end
  end

  ogft_ram #(
    .AW (MEM_AW),
    .DW (VAL_W)
  ) u_ram (
    .clk   (clk),
    .we    (mem_we),
    .addr  (mem_addr),
    .wdata (req.cell_value),
    .rdata (mem_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      tap_vld <= 1'b0;
    end else begin
      tap_vld <= cmd.scan_step;
    end
  end

  always_ff @(posedge clk) begin
    tap_ok <= tap_in;
    tap_r  <= sr;
    tap_c  <= sc;
    if (tap_vld) begin
      unk[tap_r][tap_c] <= tap_ok && (mem_rdata == unknown_code);
      if (tap_r == WIN_IW'(WIN_HALF) && tap_c == WIN_IW'(WIN_HALF)) begin
        ctr_free <= tap_ok && (mem_rdata == free_code);
      end
    end
  end

  assign frontier = ctr_free && frontier_eval(unk, min_unknown_count);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_row   <= q_row;
      out_col   <= q_col;
      out_front <= frontier;
    end
  end

  assign rsp.valid       = out_valid;
  assign rsp.result_row  = out_row;
  assign rsp.result_col  = out_col;
  assign rsp.is_frontier = out_front;

  `OGFT_ASSERT_NOW(a_accept_quiet, accept, !tap_vld && !cmd.scan_step,
    "word accepted during window scan")
  `OGFT_ASSERT_NOW(a_no_overwrite, cmd.out_load, !(out_valid && !rsp.ready),
    "pending result overwritten")
  `OGFT_ASSERT_NOW(a_write_idle, mem_we, !tap_vld,
    "cell write during window scan")

endmodule

>>> rtl/occupancy_grid_frontier_test.sv
// ----------------------------------------------------------------------------
// occupancy_grid_frontier_test
// Occupancy grid store with a per-cell frontier test.
// ----------------------------------------------------------------------------
// A write word stores one cell; writes can stream back to back. A query word
// reads the 5x5 window around the cell from the single-port cell store, one
// cell per cycle, so a query occupies the block through accept, 25 reads, a
// read-data drain and an evaluate step that waits for the output register to
// be free, after which the result sits in that register and the next word is
// taken while it waits. The store holds MAX_ROWS x MAX_COLS cells and has no
// reset; only written cells may be queried or lie in a queried cell's window
// within the grid in use. Configuration writes are taken every cycle and
// belong in idle periods.
module occupancy_grid_frontier_test import ogft_pkg::*; (
  input logic        clk,
  input logic        rst,
  ogft_req_if.sink   req,
  ogft_rsp_if.source rsp,
  ogft_cfg_if.sink   cfg
);

  ctrl_cmd_t cmd;
  dp_stat_t  stat;

  ogft_ctrl u_ctrl (
    .clk  (clk),
    .rst  (rst),
    .stat (stat),
    .cmd  (cmd)
  );

  ogft_dp u_dp (
    .clk  (clk),
    .rst  (rst),
    .req  (req),
    .rsp  (rsp),
    .cfg  (cfg),
    .cmd  (cmd),
    .stat (stat)
  );

endmodule

>>> dv/tb.sv
// ----------------------------------------------------------------------------
// tb - occupancy grid frontier test bench
// Fills cells of the grid store and queries their frontier status. A directed
// walk covers grid edges, zero and saturated limits and the threshold extremes;
// random phases then write small neighbourhoods with free and unknown codes
// and query them under four pacing modes. Each result is checked against
// a set value or a predictor with its own copy of the grid and registers.
// ----------------------------------------------------------------------------
module tb import ogft_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int SETTLE_CYCLES = 40;
  localparam int HOLD_CYCLES   = 400;
  localparam int PHASE_ITEMS   = 90;
  localparam int MAX_REPORTS   = 10;
  localparam int STORE_CELLS   = MAX_ROWS * MAX_COLS;

  typedef struct packed {
    logic [ROW_FW-1:0] row;
    logic [COL_FW-1:0] col;
    logic              flag;
  } cell_result_t;

  typedef enum {STEP_CFG, STEP_WR, STEP_QRY} step_kind_t;

  typedef struct {
    step_kind_t kind;
    cfg_idx_t   sel;
    int         a;
    int         b;
    int         c;
    int         want;
  } step_t;

  step_t directed_steps [0:24] = '{
    '{STEP_CFG, CFG_ROWS,    2,   0,   0,   -1},
    '{STEP_CFG, CFG_COLS,    2,   0,   0,   -1},
    '{STEP_WR,  CFG_ROWS,    0,   0,   0,   -1},
    '{STEP_WR,  CFG_ROWS,    0,   1,   255, -1},
    '{STEP_WR,  CFG_ROWS,    1,   0,   255, -1},
    '{STEP_WR,  CFG_ROWS,    1,   1,   255, -1},
    '{STEP_QRY, CFG_ROWS,    0,   0,   0,   -1},
    '{STEP_CFG, CFG_MIN_CNT, 0,   0,   0,   -1},
    '{STEP_QRY, CFG_ROWS,    0,   0,   0,   -1},
    '{STEP_QRY, CFG_ROWS,    1,   1,   0,   0},
    '{STEP_CFG, CFG_MIN_CNT, 15,  0,   0,   -1},
    '{STEP_QRY, CFG_ROWS,    0,   0,   0,   0},
    '{STEP_QRY, CFG_ROWS,    255, 255, 0,   0},
    '{STEP_CFG, CFG_ROWS,    0,   0,   0,   -1},
    '{STEP_QRY, CFG_ROWS,    0,   0,   0,   0},
    '{STEP_CFG, CFG_ROWS,    511, 0,   0,   -1},
    '{STEP_CFG, CFG_COLS,    511, 0,   0,   -1},
    '{STEP_CFG, CFG_MIN_CNT, 8,   0,   0,   -1},
    '{STEP_QRY, CFG_ROWS,    255, 255, 0,   -1},
    '{STEP_CFG, CFG_FREE,    255, 0,   0,   -1},
    '{STEP_CFG, CFG_UNKNOWN, 0,   0,   0,   -1},
    '{STEP_CFG, CFG_MIN_CNT, 1,   0,   0,   -1},
    '{STEP_QRY, CFG_ROWS,    0,   255, 0,   -1},
    '{STEP_WR,  CFG_ROWS,    255, 0,   255, -1},
    '{STEP_QRY, CFG_ROWS,    255, 0,   0,   -1}
  };

  logic clk = 1'b0;
  logic rst;

  ogft_req_if req_ch ();
  ogft_rsp_if rsp_ch ();
  ogft_cfg_if cfg_ch ();

  occupancy_grid_frontier_test i_dut (
    .clk(clk),
    .rst(rst),
    .req(req_ch),
    .rsp(rsp_ch),
    .cfg(cfg_ch)
  );

  always #5 clk = ~clk;

  logic [VAL_W-1:0] grid_mem [STORE_CELLS];
  bit               cell_written [STORE_CELLS];
  logic [LIM_W-1:0] lim_rows;
  logic [LIM_W-1:0] lim_cols;
  logic [VAL_W-1:0] free_val;
  logic [VAL_W-1:0] unk_val;
  logic [CNT_W-1:0] min_unk;

  cell_result_t pending_results [$];
  int   send_idle_pct;
  int   stall_pct;
  logic hold_request;
  logic hold_active;
  int   err_count;
  int   n_writes;
  int   n_queries;
  int   n_hits;
  int   n_cfg;

  function automatic int grid_rows();
    return (lim_rows > MAX_ROWS) ? MAX_ROWS : int'(lim_rows);
  endfunction

  function automatic int grid_cols();
    return (lim_cols > MAX_COLS) ? MAX_COLS : int'(lim_cols);
  endfunction

  function automatic bit in_grid(int r, int c);
    return r >= 0 && c >= 0 && r < grid_rows() && c < grid_cols();
  endfunction

  function automatic int cell_at(int r, int c);
    if (!in_grid(r, c)) return -1;
    return int'(grid_mem[r * MAX_COLS + c]);
  endfunction

  function automatic int unknown_around(int r, int c);
    int n = 0;
    for (int dr = -1; dr <= 1; dr++)
      for (int dc = -1; dc <= 1; dc++)
        if ((dr != 0 || dc != 0) && cell_at(r + dr, c + dc) == int'(unk_val)) n++;
    return n;
  endfunction

  function automatic logic frontier_flag(int r, int c);
    if (cell_at(r, c) != int'(free_val)) return 1'b0;
    for (int dr = -1; dr <= 1; dr++)
      for (int dc = -1; dc <= 1; dc++)
        if ((dr != 0 || dc != 0) && cell_at(r + dr, c + dc) == int'(unk_val) &&
            unknown_around(r + dr, c + dc) >= int'(min_unk)) return 1'b1;
    return 1'b0;
  endfunction

  function automatic int pick_value();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 35) return int'(unk_val);
    if (roll < 65) return int'(free_val);
    return $urandom_range(0, 255);
  endfunction

  function automatic int clamp_coord(int v);
    return (v < 0) ? 0 : ((v > 255) ? 255 : v);
  endfunction

  function automatic int pick_coord(int lim);
    if (lim <= 16) return $urandom_range(0, lim + 1);
    case ($urandom_range(0, 2))
      0: return $urandom_range(0, 7);
      1: return $urandom_range(124, 131);
      default: return $urandom_range(lim - 8, (lim > 255) ? 255 : lim);
    endcase
  endfunction

  task automatic report_error(string msg);
    err_count++;
    if (err_count <= MAX_REPORTS) $display("%0t: %s", $time, msg);
  endtask

  task automatic push_word(req_kind_t kind, int row, int col, int value, int want);
    cell_result_t res;
    while ($urandom_range(0, 99) < send_idle_pct) begin
      req_ch.valid <= 1'b0;
      @(posedge clk);
    end
    req_ch.valid      <= 1'b1;
    req_ch.req_type   <= kind;
    req_ch.cell_row   <= ROW_FW'(row);
    req_ch.cell_col   <= COL_FW'(col);
    req_ch.cell_value <= VAL_W'(value);
    do @(posedge clk); while (req_ch.ready !== 1'b1);
    if (kind == REQ_WRITE) begin
      grid_mem[row * MAX_COLS + col]     = VAL_W'(value);
      cell_written[row * MAX_COLS + col] = 1'b1;
      n_writes++;
    end else begin
      res.row  = ROW_FW'(row);
      res.col  = COL_FW'(col);
      res.flag = (want < 0) ? frontier_flag(row, col) : want[0];
      pending_results.insert(pending_results.size(), res);
      n_queries++;
      if (res.flag) n_hits++;
    end
  endtask

  // write every unwritten in-grid cell of the read window first
  task automatic query_cell(int row, int col, int want);
    int rr;
    int cc;
    for (int dr = -2; dr <= 2; dr++)
      for (int dc = -2; dc <= 2; dc++) begin
        rr = row + dr;
        cc = col + dc;
        if (in_grid(rr, cc) && !cell_written[rr * MAX_COLS + cc])
          push_word(REQ_WRITE, rr, cc, pick_value(), -1);
      end
    if (!cell_written[row * MAX_COLS + col])
      push_word(REQ_WRITE, row, col, pick_value(), -1);
    push_word(REQ_QUERY, row, col, 0, want);
  endtask

  task automatic write_reg(cfg_idx_t sel, int data);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= sel;
    cfg_ch.data  <= CFG_DATA_W'(data);
    do @(posedge clk); while (cfg_ch.ready !== 1'b1);
    case (sel)
      CFG_ROWS:    lim_rows = LIM_W'(data);
      CFG_COLS:    lim_cols = LIM_W'(data);
      CFG_FREE:    free_val = VAL_W'(data);
      CFG_UNKNOWN: unk_val  = VAL_W'(data);
      CFG_MIN_CNT: min_unk  = CNT_W'(data);
      default: ;
    endcase
    n_cfg++;
    cfg_ch.valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic settle_block();
    req_ch.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // hold off the receiver for a long stretch once requested
  initial begin
    hold_active <= 1'b0;
    wait (hold_request === 1'b1);
    @(posedge clk);
    hold_active <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    hold_active <= 1'b0;
  end

  always @(posedge clk) begin
    cell_result_t got;
    cell_result_t exp_res;
    if (rst) begin
      rsp_ch.ready <= 1'b0;
    end else begin
      if (rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1) begin
        got = '{rsp_ch.result_row, rsp_ch.result_col, rsp_ch.is_frontier};
        if (pending_results.size() == 0) begin
          report_error($sformatf("result row %0d col %0d with nothing outstanding",
                                 got.row, got.col));
        end else begin
          exp_res = pending_results.pop_front();
          if (got.row !== exp_res.row || got.col !== exp_res.col ||
              got.flag !== exp_res.flag)
            report_error($sformatf("row/col/frontier expected %0d/%0d/%0d got %0d/%0d/%0d",
                                   exp_res.row, exp_res.col, exp_res.flag,
                                   got.row, got.col, got.flag));
        end
      end
      if (hold_active === 1'b1) begin
        rsp_ch.ready <= 1'b0;
      end else begin
        rsp_ch.ready <= ($urandom_range(0, 99) >= stall_pct);
      end
    end
  end

  initial begin
    #5_000_000;
    $display("Verification failed");
    $finish;
  end

  initial begin
    int items;
    int r;
    int c;
    int rows_v;
    int cols_v;
    int free_v;
    int unk_v;
    int min_v;
    rst               <= 1'b1;
    req_ch.valid      <= 1'b0;
    req_ch.req_type   <= REQ_WRITE;
    req_ch.cell_row   <= '0;
    req_ch.cell_col   <= '0;
    req_ch.cell_value <= '0;
    cfg_ch.valid      <= 1'b0;
    cfg_ch.index      <= CFG_ROWS;
    cfg_ch.data       <= '0;
    hold_request      <= 1'b0;
    lim_rows = 256;
    lim_cols = 256;
    free_val = 0;
    unk_val  = 255;
    min_unk  = 4;
    send_idle_pct = 0;
    stall_pct     = 0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (directed_steps[i]) begin
      case (directed_steps[i].kind)
        STEP_CFG: begin
          settle_block();
          write_reg(directed_steps[i].sel, directed_steps[i].a);
        end
        STEP_WR: push_word(REQ_WRITE, directed_steps[i].a, directed_steps[i].b,
                           directed_steps[i].c, -1);
        default: query_cell(directed_steps[i].a, directed_steps[i].b,
                            directed_steps[i].want);
      endcase
    end

    for (int p = 0; p < 4; p++) begin
      settle_block();
      free_v = $urandom_range(0, 255);
      unk_v  = $urandom_range(0, 255);
      case (p)
        0: begin
          send_idle_pct = 0;  stall_pct = 0;
          rows_v = 256; cols_v = 256; free_v = 0; unk_v = 255; min_v = 2;
        end
        1: begin
          send_idle_pct = 77; stall_pct = 0;
          rows_v = $urandom_range(3, 12); cols_v = $urandom_range(3, 12);
          min_v  = $urandom_range(0, 8);
        end
        2: begin
          send_idle_pct = 0;  stall_pct = 77;
          rows_v = 1; cols_v = $urandom_range(257, 511); min_v = $urandom_range(0, 2);
        end
        default: begin
          send_idle_pct = 18; stall_pct = 18;
          rows_v = $urandom_range(1, 256); cols_v = $urandom_range(1, 40);
          min_v  = $urandom_range(0, 15);
        end
      endcase
      write_reg(CFG_ROWS, rows_v);
      write_reg(CFG_COLS, cols_v);
      write_reg(CFG_FREE, free_v);
      write_reg(CFG_UNKNOWN, unk_v);
      write_reg(CFG_MIN_CNT, min_v);
      if (p == 0) hold_request <= 1'b1;

      items = n_writes + n_queries;
      while (n_writes + n_queries - items < PHASE_ITEMS) begin
        if ($urandom_range(0, 99) < 10) begin
          if ($urandom_range(0, 1))
            query_cell($urandom_range(0, 255), $urandom_range(0, 255), -1);
          else
            push_word(REQ_WRITE, $urandom_range(0, 255), $urandom_range(0, 255),
                      $urandom_range(0, 255), -1);
        end else begin
          r = pick_coord(grid_rows());
          c = pick_coord(grid_cols());
          repeat ($urandom_range(1, 5)) begin
            push_word(REQ_WRITE, clamp_coord(r + int'($urandom_range(0, 4)) - 2),
                      clamp_coord(c + int'($urandom_range(0, 4)) - 2), pick_value(), -1);
          end
          if ($urandom_range(0, 1)) begin
            push_word(REQ_WRITE, r, c, int'(free_val), -1);
          end
          if ($urandom_range(0, 99) < 80)
            query_cell(r, c, -1);
          else
            query_cell(clamp_coord(r + int'($urandom_range(0, 2)) - 1),
                       clamp_coord(c + int'($urandom_range(0, 2)) - 1), -1);
        end
      end
    end

    settle_block();
    $display("Covered %0d cell writes, %0d queries (%0d frontier) and %0d register writes,",
             n_writes, n_queries, n_hits, n_cfg);
    $display("over grid edges, limit extremes, four pacing modes and a long hold-off; %0d errors.",
             err_count);
    if (err_count == 0)
      $display("Verification passed");
    else
      $display("Verification failed");
    $finish;
  end

endmodule

>>> filelist.f
+incdir+rtl
rtl/ogft_pkg.sv
rtl/ogft_req_if.sv
rtl/ogft_rsp_if.sv
rtl/ogft_cfg_if.sv
rtl/ogft_ram.sv
rtl/ogft_ctrl.sv
rtl/ogft_dp.sv
rtl/occupancy_grid_frontier_test.sv
dv/tb.sv
